@@ hdl/tods_pkg.sv @@
// ----------------------------------------------------------------------------
// Time-of-day schedule table package
// Shared types and constants for the schedule table and its checker.
// ----------------------------------------------------------------------------
package tods_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int TIME_W   = 31;
  localparam int POWER_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int MODE_W   = 2;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

  typedef struct packed {
    logic [PERIOD_W-1:0]       period;
    logic signed [POWER_W-1:0] power;
    logic                      enable;
    logic [TIME_W-1:0]         ttime;
  } rec_t;

  typedef struct packed {
    logic [TIME_W-1:0]         active_time;
    logic [PERIOD_W-1:0]       active_period;
    logic signed [POWER_W-1:0] active_power;
    logic                      beacon_on;
    logic                      apply_settings;
    logic                      switched;
    logic                      status;
  } res_t;

endpackage

@@ hdl/tods_store.sv @@
// ----------------------------------------------------------------------------
// Schedule record store
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module tods_store #(
  parameter int DEPTH = tods_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [AW-1:0]      addr,
  input  tods_pkg::rec_t     wr_data,
  output tods_pkg::rec_t     rd_data_r
);

  tods_pkg::rec_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

endmodule

@@ hdl/tods_ctrl.sv @@
// ----------------------------------------------------------------------------
// Schedule table sequencer
// Appends records, clears the table, scans the store for the due record and
// keeps the active record and the result register.
// ----------------------------------------------------------------------------
module tods_ctrl #(
  parameter int DEPTH = tods_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tods_pkg::MODE_W-1:0]  in_mode,
  input  tods_pkg::rec_t               in_rec,
  input  logic [tods_pkg::TIME_W-1:0]  in_now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tods_pkg::res_t               out_res,
  output logic                         mem_wr_en,
  output logic                         mem_rd_en,
  output logic [AW-1:0]                mem_addr,
  output tods_pkg::rec_t               mem_wr_data,
  input  tods_pkg::rec_t               mem_rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          cmp_r, cmp_nxt;
  logic                          found_r, found_nxt;
  logic                          status_r, status_nxt;
  logic [tods_pkg::TIME_W-1:0]   best_r, best_nxt;
  logic [tods_pkg::TIME_W-1:0]   now_r, now_nxt;
  tods_pkg::rec_t                pick_r, pick_nxt;
  tods_pkg::rec_t                active_r, active_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tods_pkg::res_t                res_r, res_nxt;
  logic                          accept;
  logic                          out_free;
  logic                          sw;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign mem_wr_data = in_rec;
  assign mem_wr_en   = accept && (in_mode == tods_pkg::MODE_APPEND) && (count_r < DEPTH_C);
  assign mem_rd_en   = (state_r == S_SCAN) && (idx_r < count_r);
  assign mem_addr    = (state_r == S_SCAN) ? idx_r[AW-1:0] : count_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_nxt       = cmp_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    best_nxt      = best_r;
    now_nxt       = now_r;
    pick_nxt      = pick_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    sw            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = 1'b0;
          found_nxt  = 1'b0;
          best_nxt   = '0;
          idx_nxt    = '0;
          cmp_nxt    = 1'b0;
          now_nxt    = in_now;
          state_nxt  = S_EMIT;
          case (in_mode)
            tods_pkg::MODE_APPEND: begin
              if (count_r < DEPTH_C) begin
                count_nxt = count_r + CW'(1);
              end else begin
                status_nxt = 1'b1;
              end
            end
            tods_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            tods_pkg::MODE_CHECK: begin
              if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmp_r && (mem_rd_data.ttime <= now_r) && (mem_rd_data.ttime > best_r)) begin
          best_nxt  = mem_rd_data.ttime;
          pick_nxt  = mem_rd_data;
          found_nxt = 1'b1;
        end
        if (idx_r < count_r) begin
          idx_nxt = idx_r + CW'(1);
          cmp_nxt = 1'b1;
        end else begin
          cmp_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          sw = found_r && (pick_r != active_r);
          if (sw) begin
            active_nxt = pick_r;
          end
          res_nxt.status         = status_r;
          res_nxt.switched       = sw;
          res_nxt.apply_settings = sw && pick_r.enable;
          res_nxt.beacon_on      = (count_r != '0) && active_nxt.enable;
          res_nxt.active_power   = active_nxt.power;
          res_nxt.active_period  = active_nxt.period;
          res_nxt.active_time    = active_nxt.ttime;
          out_valid_nxt          = 1'b1;
          found_nxt              = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_r       <= 1'b0;
      found_r     <= 1'b0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_r       <= cmp_nxt;
      found_r     <= found_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    best_r   <= best_nxt;
    now_r    <= now_nxt;
    pick_r   <= pick_nxt;
    res_r    <= res_nxt;
  end

endmodule

@@ hdl/time_of_day_schedule_table.sv @@
// ----------------------------------------------------------------------------
// Time-of-day schedule table
// Stores beacon schedule records and reports the record that is due.
// ----------------------------------------------------------------------------
// One beat is taken at a time. An append, a clear or an unused mode passes
// from acceptance through the emit state, which waits for a free output
// register, into that register; a check first scans the N stored records,
// since the single record memory port returns one record per cycle to the
// compare. A new beat is taken as soon as the result is in the output
// register, even while that result still waits.
module time_of_day_schedule_table #(
  parameter int TABLE_DEPTH = tods_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // transition_time, beacon_enable, beacon_power, beacon_period, system_time
  input  logic [tods_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode
  input  logic [tods_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, switched, apply_settings, beacon_on, active_power, active_period,
  // active_time
  output logic [tods_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tods_pkg::rec_t              in_rec;
  tods_pkg::rec_t              wr_data;
  tods_pkg::rec_t              rd_data;
  tods_pkg::res_t              res;
  logic                        wr_en;
  logic                        rd_en;
  logic [AW-1:0]               addr;
  logic [tods_pkg::TIME_W-1:0] now;

  assign in_rec.ttime  = in_tdata[30:0];
  assign in_rec.enable = in_tdata[31];
  assign in_rec.power  = in_tdata[39:32];
  assign in_rec.period = in_tdata[55:40];
  assign now           = in_tdata[86:56];

  assign out_tdata = {5'd0, res};

  tods_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_rec      (in_rec),
    .in_now      (now),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res),
    .mem_wr_en   (wr_en),
    .mem_rd_en   (rd_en),
    .mem_addr    (addr),
    .mem_wr_data (wr_data),
    .mem_rd_data (rd_data)
  );

  tods_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .rd_en     (rd_en),
    .addr      (addr),
    .wr_data   (wr_data),
    .rd_data_r (rd_data)
  );

endmodule

@@ hdl/tods_checker.sv @@
// ----------------------------------------------------------------------------
// Schedule table port checker
// Watches the ports of the schedule table for slips in its sequencing.
// ----------------------------------------------------------------------------
module tods_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tods_pkg::IN_USER_W-1:0]    in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tods_pkg::OUT_DATA_W-1:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while one is in work");

  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != tods_pkg::MODE_CHECK) && !out_tvalid
    |-> ##2 out_tvalid)
    else $error("result of a non-check beat is late");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1] && !out_tdata[2])
    else $error("refused append reports a switch");

  a_apply_implies: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && out_tdata[3])
    else $error("settings applied without a switch to an enabled record");

endmodule

bind time_of_day_schedule_table tods_checker u_tods_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/time_of_day_schedule_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day schedule table testbench
// Drives append, clear, check and unused-mode beats into the schedule table
// and compares every result beat against a cycle-free predictor of the
// table. A directed opening covers the zero-time record, ties, the empty
// table and clearing. The random part is mostly fill-then-check sequences,
// with a few that fill the table past full, mixed with noise beats. Both
// sides idle at random in several phases.
// ----------------------------------------------------------------------------
module time_of_day_schedule_table_tb;

  typedef logic [tods_pkg::MODE_W-1:0]   mode_t;
  typedef logic [tods_pkg::TIME_W-1:0]   time_t;
  typedef logic [tods_pkg::POWER_W-1:0]  power_t;
  typedef logic [tods_pkg::PERIOD_W-1:0] period_t;

  localparam int    DEPTH       = tods_pkg::TABLE_DEPTH_DEF;
  localparam int    RAND_ITEMS  = 1150;
  localparam int    PHASE_LEN   = 150;
  localparam int    DRAIN_WAIT  = 100;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam time_t TIME_MAX    = {tods_pkg::TIME_W{1'b1}};

  typedef struct {
    mode_t          mode;
    tods_pkg::rec_t rec;
    time_t          now;
    bit             drain;
  } sched_cmd_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tods_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [tods_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tods_pkg::OUT_DATA_W-1:0] out_tdata;

  sched_cmd_t     pending_cmds[$];
  tods_pkg::res_t expected_res[$];

  tods_pkg::rec_t sched_mem [DEPTH];
  int unsigned    sched_cnt = 0;
  tods_pkg::rec_t live_rec  = '0;

  int unsigned tx_cnt       = 0;
  int unsigned rx_cnt       = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  time_of_day_schedule_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic tods_pkg::res_t predict_result(sched_cmd_t c);
    tods_pkg::res_t r;
    tods_pkg::rec_t pick;
    time_t          best;
    bit             found;
    int             i;
    r     = '0;
    pick  = '0;
    best  = '0;
    found = 1'b0;
    case (c.mode)
      tods_pkg::MODE_APPEND: begin
        if (sched_cnt < DEPTH) begin
          sched_mem[sched_cnt] = c.rec;
          sched_cnt++;
        end else begin
          r.status = 1'b1;
        end
      end
      tods_pkg::MODE_CLEAR: begin
        sched_cnt = 0;
      end
      tods_pkg::MODE_CHECK: begin
        for (i = 0; i < sched_cnt; i++) begin
          if (sched_mem[i].ttime <= c.now && sched_mem[i].ttime > best) begin
            best  = sched_mem[i].ttime;
            pick  = sched_mem[i];
            found = 1'b1;
          end
        end
        if (found && pick != live_rec) begin
          live_rec         = pick;
          r.switched       = 1'b1;
          r.apply_settings = pick.enable;
        end
      end
      default: begin
      end
    endcase
    r.beacon_on     = (sched_cnt > 0) && live_rec.enable;
    r.active_power  = live_rec.power;
    r.active_period = live_rec.period;
    r.active_time   = live_rec.ttime;
    return r;
  endfunction

  function automatic int idle_pct(int unsigned cnt, bit rx_side);
    case ((cnt / PHASE_LEN) % 4)
      1:       return rx_side ? 0 : 82;
      2:       return rx_side ? 82 : 0;
      3:       return 29;
      default: return 0;
    endcase
  endfunction

  function automatic tods_pkg::rec_t make_rec(time_t t, logic en, power_t pw, period_t per);
    tods_pkg::rec_t r;
    r.ttime  = t;
    r.enable = en;
    r.power  = pw;
    r.period = per;
    return r;
  endfunction

  function automatic tods_pkg::rec_t random_rec();
    time_t t;
    case ($urandom_range(0, 9))
      0:          t = '0;
      1:          t = TIME_MAX;
      2, 3, 4, 5: t = time_t'($urandom_range(1, 24));
      default:    t = time_t'($urandom());
    endcase
    return make_rec(t, 1'($urandom_range(0, 1)), power_t'($urandom()),
                    period_t'($urandom()));
  endfunction

  task automatic add_cmd(mode_t mode, tods_pkg::rec_t rec, time_t now, bit drain);
    sched_cmd_t c;
    c.mode  = mode;
    c.rec   = rec;
    c.now   = now;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatch_cnt++;
    end
  endtask

  // Driver: one beat in flight, held until accepted.
  always @(posedge clk) begin
    sched_cmd_t c;
    bit         hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      hold = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        c.mode = in_tuser;
        c.rec  = tods_pkg::rec_t'(in_tdata[55:0]);
        c.now  = in_tdata[86:56];
        expected_res.push_back(predict_result(c));
        tx_cnt++;
      end
      if (!hold) begin
        if (pending_cmds.size() > 0
            && !(pending_cmds[0].drain && expected_res.size() != 0)
            && $urandom_range(0, 99) >= idle_pct(tx_cnt, 1'b0)) begin
          c = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= c.mode;
          in_tdata  <= {1'b0, c.now, c.rec};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    tods_pkg::res_t got;
    tods_pkg::res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = tods_pkg::res_t'(out_tdata[58:0]);
        if (expected_res.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          mismatch_cnt++;
        end else begin
          want = expected_res.pop_front();
          check_field("status", want.status, got.status);
          check_field("switched", want.switched, got.switched);
          check_field("apply_settings", want.apply_settings, got.apply_settings);
          check_field("beacon_on", want.beacon_on, got.beacon_on);
          check_field("active_power", $signed(want.active_power), $signed(got.active_power));
          check_field("active_period", want.active_period, got.active_period);
          check_field("active_time", want.active_time, got.active_time);
        end
        rx_cnt++;
      end
      out_tready <= ($urandom_range(0, 99) >= idle_pct(rx_cnt, 1'b1));
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    time_t          gen_times[$];
    time_t          now;
    int unsigned    n_rand;
    int unsigned    gen_cnt;
    int unsigned    n_app;
    int unsigned    n_chk;
    int unsigned    k;
    int unsigned    j;
    bit             first_seq;
    tods_pkg::rec_t r;
    mode_t          m;

    // Directed opening.
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec('0, 1'b1, 8'h80, 16'hFFFF), '0, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec(TIME_MAX, 1'b0, 8'h7F, 16'h0000), '0, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec(31'd5, 1'b1, 8'hFF, 16'd1234), '0, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec(31'd5, 1'b0, 8'h03, 16'd7), '0, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd0, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd4, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd5, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd5, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX - 31'd1, 1'b0);
    add_cmd(MODE_UNUSED, make_rec(TIME_MAX, 1'b1, 8'hFF, 16'hFFFF), TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_CLEAR, make_rec(TIME_MAX, 1'b1, 8'hFF, 16'hFFFF), TIME_MAX,
            1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec(TIME_MAX, 1'b1, 8'hFF, 16'hFFFF), TIME_MAX,
            1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, TIME_MAX, 1'b0);
    add_cmd(tods_pkg::MODE_APPEND, make_rec(31'd1, 1'b1, 8'h00, 16'd1), '0, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd1, 1'b0);
    add_cmd(tods_pkg::MODE_CLEAR, '0, '0, 1'b0);
    add_cmd(tods_pkg::MODE_CHECK, '0, 31'd1, 1'b0);

    // Random part: fill-then-check sequences with some noise beats.
    n_rand    = 0;
    gen_cnt   = 0;
    first_seq = 1'b1;
    while (n_rand < RAND_ITEMS) begin
      if (!first_seq && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) begin
          m = mode_t'($urandom_range(0, 3));
          r = random_rec();
          add_cmd(m, r, time_t'($urandom()), 1'b0);
          if (m == tods_pkg::MODE_APPEND) begin
            if (gen_cnt < DEPTH) gen_times.push_back(r.ttime);
            gen_cnt++;
          end else if (m == tods_pkg::MODE_CLEAR) begin
            gen_cnt = 0;
            gen_times.delete();
          end
          if (m != MODE_UNUSED) n_rand++;
        end
      end else begin
        if (first_seq || $urandom_range(0, 3) != 0) begin
          add_cmd(tods_pkg::MODE_CLEAR, random_rec(), time_t'($urandom()),
                  first_seq || $urandom_range(0, 11) == 0);
          gen_cnt = 0;
          gen_times.delete();
          n_rand++;
        end
        if (first_seq) n_app = 66;
        else if ($urandom_range(0, 7) == 0) n_app = $urandom_range(56, 70);
        else n_app = $urandom_range(0, 8);
        for (j = 0; j < n_app; j++) begin
          r = random_rec();
          if (gen_times.size() > 0 && $urandom_range(0, 5) == 0)
            r.ttime = gen_times[$urandom_range(0, gen_times.size() - 1)];
          add_cmd(tods_pkg::MODE_APPEND, r, time_t'($urandom()), 1'b0);
          if (gen_cnt < DEPTH) gen_times.push_back(r.ttime);
          gen_cnt++;
          n_rand++;
        end
        n_chk = $urandom_range(1, 5);
        for (j = 0; j < n_chk; j++) begin
          k = $urandom_range(0, 9);
          if (k == 0) now = '0;
          else if (k == 1) now = TIME_MAX;
          else if (k <= 6 && gen_times.size() > 0) begin
            now = gen_times[$urandom_range(0, gen_times.size() - 1)];
            case ($urandom_range(0, 2))
              0:       now = now - 31'd1;
              1:       now = now + 31'd1;
              default: now = now;
            endcase
          end else if (k == 7) now = time_t'($urandom_range(0, 30));
          else now = time_t'($urandom());
          add_cmd(tods_pkg::MODE_CHECK, random_rec(), now, 1'b0);
          n_rand++;
        end
        first_seq = 1'b0;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid || expected_res.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0 && expected_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tods_pkg.sv
hdl/tods_store.sv
hdl/tods_ctrl.sv
hdl/time_of_day_schedule_table.sv
hdl/tods_checker.sv
tb/sv/time_of_day_schedule_table_tb.sv
